// ===== sv/assert_macros.svh =====
// Assertion macros used by fsva_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is held low.
`define FSVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is held low.
`define FSVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FSVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FSVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/fsva_pkg.sv =====
package fsva_pkg;

    localparam int VOICES          = 4;
    localparam int NOTES_PER_VOICE = 16;
    localparam int CODE_BITS       = 16;
    localparam int LEN_BITS        = 7;
    localparam int TICK_BITS       = 11;
    localparam int MEAS_BITS       = 16;
    localparam int VOICE_BITS      = 2;
    localparam int SLOT_BITS       = (NOTES_PER_VOICE > 1) ? $clog2(NOTES_PER_VOICE) : 1;
    localparam int CNT_BITS        = $clog2(NOTES_PER_VOICE + 1);
    localparam int HEAD_BITS       = $clog2(NOTES_PER_VOICE + 2);

    // Command queue between the front and the back.
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // Request kinds, as carried in the func field.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [MEAS_BITS-1:0] MEAS_MAX = {MEAS_BITS{1'b1}};

    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef struct packed {
        logic                        kind;
        logic [VOICE_BITS-1:0]       voice;
        logic [SLOT_BITS-1:0]        slot;
        logic [CODE_BITS-1:0]        code;
        logic [LEN_BITS-1:0]         len;
        t_cnt [VOICES-1:0]           counts;
        logic [MEAS_BITS-1:0]        measure;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== sv/fsva_front.sv =====
module fsva_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_func,
    input  logic [1:0]       i_voice,
    input  logic [15:0]      i_note_code,
    input  logic [6:0]       i_duration,
    input  fsva_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output fsva_pkg::t_cmd   o_cmd
);
    import fsva_pkg::*;

    t_cnt [VOICES-1:0]      r_cnt, n_cnt;
    logic [MEAS_BITS-1:0]   r_meas, n_meas;
    logic                   w_accept;

    // A request is taken whenever the command queue has room.
    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;

    // Classify the request: assign a slot to a note, drop it when its voice is full,
    // or stamp a measure end with the note counts and the measure number.
    always_comb begin
        n_cnt          = r_cnt;
        n_meas         = r_meas;
        o_push         = 1'b0;
        o_cmd.kind     = i_func;
        o_cmd.voice    = i_voice;
        o_cmd.slot     = r_cnt[i_voice][SLOT_BITS-1:0];
        o_cmd.code     = i_note_code;
        o_cmd.len      = i_duration;
        o_cmd.counts   = r_cnt;
        o_cmd.measure  = r_meas;
        if (w_accept) begin
            if (i_func == CMD_END) begin
                o_push = 1'b1;
                n_cnt  = '0;
                if (r_meas != MEAS_MAX) begin
                    n_meas = r_meas + MEAS_BITS'(1);
                end
            end else if (r_cnt[i_voice] < CNT_BITS'(NOTES_PER_VOICE)) begin
                o_push          = 1'b1;
                n_cnt[i_voice]  = r_cnt[i_voice] + CNT_BITS'(1);
            end
        end
    end

    // Note counts and the measure number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_meas <= MEAS_BITS'(1);
        end else begin
            r_cnt  <= n_cnt;
            r_meas <= n_meas;
        end
    end

endmodule

// ===== sv/fsva_cmd_fifo.sv =====
module fsva_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fsva_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output fsva_pkg::t_cmd    o_head,
    output fsva_pkg::t_q_stat o_stat
);
    import fsva_pkg::*;

    t_cmd                   r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  r_wr_ptr;
    logic [Q_PTR_BITS-1:0]  r_rd_ptr;
    logic [Q_CNT_BITS-1:0]  r_count;
    logic                   w_push;
    logic                   w_pop;

    assign o_stat.full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_BITS'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + Q_CNT_BITS'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - Q_CNT_BITS'(1);
            end
        end
    end

endmodule

// ===== sv/fsva_back.sv =====
`include "assert_macros.svh"

module fsva_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fsva_pkg::t_q_stat i_q_stat,
    input  fsva_pkg::t_cmd    i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_measure_number,
    output logic [10:0]       o_segment_start,
    output logic [10:0]       o_segment_length,
    output logic [15:0]       o_soprano_code,
    output logic [15:0]       o_alto_code,
    output logic [15:0]       o_tenor_code,
    output logic [15:0]       o_bass_code,
    output logic              o_soprano_present,
    output logic              o_alto_present,
    output logic              o_tenor_present,
    output logic              o_bass_present,
    output logic              o_run_last
);
    import fsva_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_MERGE = 1'b1;

    // Note banks, one per voice.
    logic [CODE_BITS-1:0]   r_code_mem [VOICES][NOTES_PER_VOICE];
    logic [LEN_BITS-1:0]    r_len_mem  [VOICES][NOTES_PER_VOICE];
    logic [CODE_BITS-1:0]   r_rd_code  [VOICES];
    logic [LEN_BITS-1:0]    r_rd_len   [VOICES];

    logic                   r_state, n_state;
    t_cnt                   r_cnt [VOICES];
    t_cnt                   n_cnt [VOICES];
    logic [MEAS_BITS-1:0]   r_meas, n_meas;
    logic [HEAD_BITS-1:0]   r_h [VOICES];
    logic [HEAD_BITS-1:0]   n_h [VOICES];
    logic [TICK_BITS-1:0]   r_val [VOICES];
    logic [TICK_BITS-1:0]   n_val [VOICES];
    logic [CODE_BITS-1:0]   r_cur_code [VOICES];
    logic [CODE_BITS-1:0]   n_cur_code [VOICES];
    logic                   r_first, n_first;
    logic [TICK_BITS-1:0]   r_last, n_last;
    logic                   r_have_pend, n_have_pend;

    // Pending segment, held until the next boundary shows whether it is the last.
    logic [TICK_BITS-1:0]   r_p_start, n_p_start;
    logic [TICK_BITS-1:0]   r_p_len, n_p_len;
    logic [CODE_BITS-1:0]   r_p_code [VOICES];
    logic [CODE_BITS-1:0]   n_p_code [VOICES];
    logic [VOICES-1:0]      r_p_pres, n_p_pres;

    // Output register.
    logic                   r_o_valid;
    logic [MEAS_BITS-1:0]   r_o_meas;
    logic [TICK_BITS-1:0]   r_o_start;
    logic [TICK_BITS-1:0]   r_o_len;
    logic [CODE_BITS-1:0]   r_o_code [VOICES];
    logic [VOICES-1:0]      r_o_pres;
    logic                   r_o_last;

    logic [VOICES-1:0]      w_act;
    logic                   w_any_act;
    logic [TICK_BITS-1:0]   w_min;
    logic                   w_new_bnd;
    logic                   w_need_push;
    logic                   w_out_free;
    logic                   w_stall;
    logic                   w_push_out;
    logic                   w_wr_en;
    logic [VOICES-1:0]      w_pres;
    logic [CODE_BITS-1:0]   w_snap_code [VOICES];
    logic [SLOT_BITS-1:0]   w_rd_addr [VOICES];

    // Head status of each voice and the smallest head boundary.
    always_comb begin
        w_min = {TICK_BITS{1'b1}};
        for (int v = 0; v < VOICES; v++) begin
            w_act[v]       = (r_h[v] <= HEAD_BITS'(r_cnt[v]));
            w_pres[v]      = w_act[v] && (r_h[v] != '0);
            w_snap_code[v] = w_pres[v] ? r_cur_code[v] : '0;
            if (w_act[v] && (r_val[v] < w_min)) begin
                w_min = r_val[v];
            end
        end
    end

    assign w_any_act   = |w_act;
    assign w_new_bnd   = w_any_act && (r_first || (w_min != r_last));
    assign w_need_push = (r_state == S_MERGE) && r_have_pend && (w_new_bnd || !w_any_act);
    assign w_out_free  = !r_o_valid || i_ready;
    assign w_stall     = w_need_push && !w_out_free;
    assign w_push_out  = w_need_push && w_out_free;
    assign o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
    assign w_wr_en     = o_pop && (i_head.kind == CMD_LOAD);

    // Merge sequencer: heads at the minimum boundary advance; stalls hold them.
    always_comb begin
        n_state     = r_state;
        n_meas      = r_meas;
        n_first     = r_first;
        n_last      = r_last;
        n_have_pend = r_have_pend;
        n_p_start   = r_p_start;
        n_p_len     = r_p_len;
        n_p_pres    = r_p_pres;
        for (int v = 0; v < VOICES; v++) begin
            n_cnt[v]      = r_cnt[v];
            n_h[v]        = r_h[v];
            n_val[v]      = r_val[v];
            n_cur_code[v] = r_cur_code[v];
            n_p_code[v]   = r_p_code[v];
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && (i_head.kind == CMD_END)) begin
                    n_state     = S_MERGE;
                    n_meas      = i_head.measure;
                    n_first     = 1'b1;
                    n_have_pend = 1'b0;
                    for (int v = 0; v < VOICES; v++) begin
                        n_cnt[v] = i_head.counts[v];
                        n_h[v]   = '0;
                        n_val[v] = '0;
                    end
                end
            end
            S_MERGE: begin
                if (!w_stall) begin
                    if (!w_any_act) begin
                        n_have_pend = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        if (w_new_bnd) begin
                            n_first = 1'b0;
                            n_last  = w_min;
                            if (!r_first) begin
                                n_have_pend = 1'b1;
                                n_p_start   = r_last;
                                n_p_len     = w_min - r_last;
                                n_p_pres    = w_pres;
                                for (int v = 0; v < VOICES; v++) begin
                                    n_p_code[v] = w_snap_code[v];
                                end
                            end
                        end
                        for (int v = 0; v < VOICES; v++) begin
                            if (w_act[v] && (r_val[v] == w_min)) begin
                                n_h[v]        = r_h[v] + HEAD_BITS'(1);
                                n_val[v]      = r_val[v] +
                                    {{(TICK_BITS-LEN_BITS){1'b0}}, r_rd_len[v]};
                                n_cur_code[v] = r_rd_code[v];
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        for (int v = 0; v < VOICES; v++) begin
            w_rd_addr[v] = n_h[v][SLOT_BITS-1:0];
        end
    end

    // Note banks: written on a load request, read at each voice's next head.
    always_ff @(posedge i_clk) begin
        for (int v = 0; v < VOICES; v++) begin
            if (w_wr_en && (i_head.voice == VOICE_BITS'(v))) begin
                r_code_mem[v][i_head.slot] <= i_head.code;
                r_len_mem[v][i_head.slot]  <= i_head.len;
            end
            r_rd_code[v] <= r_code_mem[v][w_rd_addr[v]];
            r_rd_len[v]  <= r_len_mem[v][w_rd_addr[v]];
        end
    end

    // Sequencer control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= 1'b1;
            r_have_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_have_pend <= n_have_pend;
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        r_meas    <= n_meas;
        r_last    <= n_last;
        r_p_start <= n_p_start;
        r_p_len   <= n_p_len;
        r_p_pres  <= n_p_pres;
        for (int v = 0; v < VOICES; v++) begin
            r_cnt[v]      <= n_cnt[v];
            r_h[v]        <= n_h[v];
            r_val[v]      <= n_val[v];
            r_cur_code[v] <= n_cur_code[v];
            r_p_code[v]   <= n_p_code[v];
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_push_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_push_out) begin
            r_o_meas  <= r_meas;
            r_o_start <= r_p_start;
            r_o_len   <= r_p_len;
            r_o_pres  <= r_p_pres;
            r_o_last  <= !w_any_act;
            for (int v = 0; v < VOICES; v++) begin
                r_o_code[v] <= r_p_code[v];
            end
        end
    end

    assign o_valid           = r_o_valid;
    assign o_measure_number  = r_o_meas;
    assign o_segment_start   = r_o_start;
    assign o_segment_length  = r_o_len;
    assign o_soprano_code    = r_o_code[0];
    assign o_alto_code       = r_o_code[1];
    assign o_tenor_code      = r_o_code[2];
    assign o_bass_code       = r_o_code[3];
    assign o_soprano_present = r_o_pres[0];
    assign o_alto_present    = r_o_pres[1];
    assign o_tenor_present   = r_o_pres[2];
    assign o_bass_present    = r_o_pres[3];
    assign o_run_last        = r_o_last;

    // Checks on the merge sequencer.
    `FSVA_ASSERT_IMPL(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_have_pend, "pending segment left in idle")
    `FSVA_ASSERT_IMPL(a_seg_len_nonzero, i_clk, i_rst_n, r_o_valid, r_o_len != '0, "zero length segment")
    `FSVA_ASSERT_IMPL(a_bnd_monotonic, i_clk, i_rst_n, (r_state == S_MERGE) && w_any_act && !r_first, w_min >= r_last, "boundary went backward")
    `FSVA_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_push_out && !w_any_act, (r_state == S_IDLE) && r_o_valid && r_o_last, "final segment did not end the measure")

endmodule

// ===== sv/four_voice_segment_aligner_core.sv =====
// Flow: an accepted request is registered in the queue and popped by the back while it is idle; a
// note is then written to its bank, and a measure end starts a merge that steps through the note
// boundaries, segments leaving at most one per cycle and output stalls holding the merge.
// Throughput: note requests are taken one per cycle while the four-entry queue has room. Reset:
// synchronous, active low; clears queue, note counts, sequencer control state and output valid,
// sets the measure number to one, not the note banks.
module four_voice_segment_aligner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [1:0]  i_voice,
    input  logic [15:0] i_note_code,
    input  logic [6:0]  i_duration,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_measure_number,
    output logic [10:0] o_segment_start,
    output logic [10:0] o_segment_length,
    output logic [15:0] o_soprano_code,
    output logic [15:0] o_alto_code,
    output logic [15:0] o_tenor_code,
    output logic [15:0] o_bass_code,
    output logic        o_soprano_present,
    output logic        o_alto_present,
    output logic        o_tenor_present,
    output logic        o_bass_present,
    output logic        o_run_last
);
    import fsva_pkg::*;

    t_q_stat w_q_stat;
    t_cmd    w_push_cmd;
    t_cmd    w_head;
    logic    w_push;
    logic    w_pop;

    // Request intake and classification.
    fsva_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_voice     (i_voice),
        .i_note_code (i_note_code),
        .i_duration  (i_duration),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    // Command queue between intake and merge.
    fsva_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Note storage, boundary merge and result output.
    fsva_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_stat          (w_q_stat),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_measure_number  (o_measure_number),
        .o_segment_start   (o_segment_start),
        .o_segment_length  (o_segment_length),
        .o_soprano_code    (o_soprano_code),
        .o_alto_code       (o_alto_code),
        .o_tenor_code      (o_tenor_code),
        .o_bass_code       (o_bass_code),
        .o_soprano_present (o_soprano_present),
        .o_alto_present    (o_alto_present),
        .o_tenor_present   (o_tenor_present),
        .o_bass_present    (o_bass_present),
        .o_run_last        (o_run_last)
    );

endmodule
